// ----- hw/rtl/hpg_pkg.sv -----
package hpg_pkg;

  // Field widths of the request and response transactions
  localparam int unsigned PosW   = 3;
  localparam int unsigned OutW   = 32;
  localparam int unsigned CountW = 4;

  // Request type codes
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqNext  = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EMIT_RD = 6'b000010,
    S_EMIT_WR = 6'b000100,
    S_ADV_RD  = 6'b001000,
    S_SWAP_A  = 6'b010000,
    S_SWAP_B  = 6'b100000
  } state_e;

  // Commands to the level counter bank
  typedef struct packed {
    logic clear;  // zero every level counter
    logic step;   // advance the counter of the selected level, wrap at the level
  } lvl_cmd_t;

endpackage

// ----- hw/rtl/hpg_if.sv -----
interface hpg_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic [hpg_pkg::PosW-1:0]              elem_position;
  logic signed [hpg_pkg::OutW-1:0]       elem_value;

  modport source (output valid, req_type, elem_position, elem_value, input ready);
  modport sink   (input valid, req_type, elem_position, elem_value, output ready);
endinterface

interface hpg_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [hpg_pkg::OutW-1:0]       out_value;
  logic [hpg_pkg::PosW-1:0]              out_position;
  logic                                  last_of_perm;
  logic                                  final_perm;
  logic                                  exhausted;

  modport source (output valid, out_value, out_position, last_of_perm, final_perm, exhausted,
                  input ready);
  modport sink   (input valid, out_value, out_position, last_of_perm, final_perm, exhausted,
                  output ready);
endinterface

// ----- hw/rtl/heap_permutation_generator.sv -----
// Heap's-algorithm permutation generator. Load up to MAX_ELEMENTS values with
// write requests (each write restarts the enumeration, as does a write of
// element_count), then send next requests: each one returns the current
// arrangement as n response transactions, positions 0..n-1, the last one
// flagged, and then steps to the following arrangement in place. Once every
// arrangement has been returned, or when n is zero, a next request returns a
// single transaction flagged exhausted. A next request reads and emits the
// elements one by one through the single-entry output register, waiting while
// the sink stalls, then advances, each level visited being a two-port read and
// two writes of the element memory; the walk may climb past the top level. A
// new request is accepted only while idle with the output register free. The
// user must write element_count only while the block is idle; the block itself
// does not enforce this.
module heap_permutation_generator #(
  parameter int unsigned MAX_ELEMENTS = 8,
  parameter int unsigned VALUE_BITS   = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hpg_req_if.sink                     req,
  hpg_rsp_if.source                   rsp,
  input  logic                        cfg_we_i,
  input  logic [hpg_pkg::CountW-1:0]  cfg_wdata_i
);

  localparam int unsigned AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned LW    = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned KW    = $clog2(MAX_ELEMENTS + 2);
  localparam int unsigned LoadW = (VALUE_BITS < hpg_pkg::OutW) ? VALUE_BITS : hpg_pkg::OutW;

  hpg_pkg::state_e state_q, state_d;

  logic [hpg_pkg::CountW-1:0] count_q;
  logic                       done_flag_q, done_flag_d;
  logic                       fin_q, fin_d;
  logic [AW-1:0]              i_q, i_d;
  logic [KW-1:0]              k_q, k_d;
  logic [AW-1:0]              a_q, a_d;
  logic [AW-1:0]              b_q, b_d;
  logic                       lvl_last_q, lvl_last_d;

  logic                              out_vld_q, out_vld_d;
  logic signed [hpg_pkg::OutW-1:0]   out_val_q, out_val_d;
  logic [hpg_pkg::PosW-1:0]          out_pos_q, out_pos_d;
  logic                              out_last_q, out_last_d;
  logic                              out_fin_q, out_fin_d;
  logic                              out_exh_q, out_exh_d;

  logic [LW-1:0]         n_act;
  logic                  out_free;
  logic                  in_acc;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [VALUE_BITS-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;
  hpg_pkg::lvl_cmd_t     lvl_cmd;
  logic [LW-1:0]         lvl_idx;
  logic [AW-1:0]         lvl_cnt;
  logic                  lvl_wrap;
  logic                  lvl_all_last;

  // Saturate the element count at the store depth
  assign n_act = (int'(count_q) > int'(MAX_ELEMENTS)) ? LW'(MAX_ELEMENTS) : LW'(count_q);

  assign out_free  = !out_vld_q || rsp.ready;
  assign req.ready = (state_q == hpg_pkg::S_IDLE) && out_free;
  assign in_acc    = req.valid && req.ready;
  assign lvl_idx   = LW'(k_q);

  hpg_elem_mem #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (VALUE_BITS),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  hpg_level_ctr #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .AW           (AW),
    .LW           (LW)
  ) u_lvl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (lvl_cmd),
    .lvl_i  (lvl_idx),
    .n_i    (n_act),
    .cnt_o  (lvl_cnt),
    .wrap_o (lvl_wrap),
    .last_o (lvl_all_last)
  );

  // Sequence writes, element emission and the level walk
  always_comb begin
    state_d     = state_q;
    done_flag_d = done_flag_q;
    fin_d       = fin_q;
    i_d         = i_q;
    k_d         = k_q;
    a_d         = a_q;
    b_d         = b_q;
    lvl_last_d  = lvl_last_q;
    out_vld_d   = out_vld_q && !rsp.ready;
    out_val_d   = out_val_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    out_fin_d   = out_fin_q;
    out_exh_d   = out_exh_q;
    mem_we      = 1'b0;
    mem_waddr   = AW'(req.elem_position);
    mem_wdata   = VALUE_BITS'(req.elem_value[LoadW-1:0]);
    mem_re      = 1'b0;
    mem_raddr_a = i_q;
    mem_raddr_b = AW'(k_q - KW'(1));
    lvl_cmd     = '0;

    unique case (state_q)
      hpg_pkg::S_IDLE: begin
        if (in_acc) begin
          if (req.req_type == hpg_pkg::ReqWrite) begin
            // Store the element when in range and restart
            mem_we        = int'(req.elem_position) < int'(MAX_ELEMENTS);
            lvl_cmd.clear = 1'b1;
            done_flag_d   = 1'b0;
          end else if ((n_act == '0) || done_flag_q) begin
            out_vld_d  = 1'b1;
            out_val_d  = '0;
            out_pos_d  = '0;
            out_last_d = 1'b1;
            out_fin_d  = 1'b0;
            out_exh_d  = 1'b1;
          end else begin
            fin_d   = lvl_all_last;
            i_d     = '0;
            state_d = hpg_pkg::S_EMIT_RD;
          end
        end
      end

      hpg_pkg::S_EMIT_RD: begin
        mem_re  = 1'b1;
        state_d = hpg_pkg::S_EMIT_WR;
      end

      hpg_pkg::S_EMIT_WR: begin
        // Hand the element to the output register once it is free
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_val_d  = hpg_pkg::OutW'(mem_rdata_a[LoadW-1:0]);
          out_pos_d  = hpg_pkg::PosW'(i_q);
          out_last_d = (LW'(i_q) + LW'(1)) == n_act;
          out_fin_d  = fin_q;
          out_exh_d  = 1'b0;
          if ((LW'(i_q) + LW'(1)) == n_act) begin
            k_d     = KW'(2);
            state_d = hpg_pkg::S_ADV_RD;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = hpg_pkg::S_EMIT_RD;
          end
        end
      end

      hpg_pkg::S_ADV_RD: begin
        if (k_q > KW'(n_act)) begin
          // Climbed past the top level: no arrangement remains
          done_flag_d = 1'b1;
          state_d     = hpg_pkg::S_IDLE;
        end else begin
          mem_re      = 1'b1;
          mem_raddr_a = k_q[0] ? '0 : lvl_cnt;
          a_d         = mem_raddr_a;
          b_d         = mem_raddr_b;
          lvl_cmd.step = 1'b1;
          lvl_last_d  = !lvl_wrap;
          if (lvl_wrap) begin
            k_d = k_q + KW'(1);
          end
          state_d = hpg_pkg::S_SWAP_A;
        end
      end

      hpg_pkg::S_SWAP_A: begin
        mem_we    = 1'b1;
        mem_waddr = a_q;
        mem_wdata = mem_rdata_b;
        state_d   = hpg_pkg::S_SWAP_B;
      end

      hpg_pkg::S_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = b_q;
        mem_wdata = mem_rdata_a;
        state_d   = lvl_last_q ? hpg_pkg::S_IDLE : hpg_pkg::S_ADV_RD;
      end

      default: begin
        state_d = hpg_pkg::S_IDLE;
      end
    endcase

    // Writing the count restarts the enumeration
    if (cfg_we_i) begin
      lvl_cmd.clear = 1'b1;
      done_flag_d   = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hpg_pkg::S_IDLE;
      count_q     <= '0;
      done_flag_q <= 1'b0;
      out_vld_q   <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      lvl_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_flag_q <= done_flag_d;
      out_vld_q   <= out_vld_d;
      i_q         <= i_d;
      k_q         <= k_d;
      lvl_last_q  <= lvl_last_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fin_q      <= fin_d;
    a_q        <= a_d;
    b_q        <= b_d;
    out_val_q  <= out_val_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
    out_fin_q  <= out_fin_d;
    out_exh_q  <= out_exh_d;
  end

  assign rsp.valid        = out_vld_q;
  assign rsp.out_value    = out_val_q;
  assign rsp.out_position = out_pos_q;
  assign rsp.last_of_perm = out_last_q;
  assign rsp.final_perm   = out_fin_q;
  assign rsp.exhausted    = out_exh_q;

  // A swap write always follows the two-port read of the level walk
  a_swap_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hpg_pkg::S_SWAP_A |-> $past(state_q) == hpg_pkg::S_ADV_RD)
    else $error("swap write without preceding read");

  // The level index of the walk stays within 2..n+1, n+1 meaning past the top
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hpg_pkg::S_ADV_RD |-> (k_q >= KW'(2)) && (k_q <= KW'(n_act) + KW'(1)))
    else $error("level index out of range");

  // An exhausted result is a lone, last, non-final transaction
  a_exh_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_exh_q |-> out_last_q && !out_fin_q && (out_pos_q == '0))
    else $error("malformed exhausted result");

  // Exhaustion is only reached by climbing out of the level walk
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_flag_q) |-> $past(state_q) == hpg_pkg::S_ADV_RD)
    else $error("finished flag set outside the level walk");

endmodule

// ----- hw/rtl/hpg_elem_mem.sv -----
module hpg_elem_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read two entries, hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- hw/rtl/hpg_level_ctr.sv -----
module hpg_level_ctr #(
  parameter int unsigned MAX_ELEMENTS = 8,
  parameter int unsigned AW = 3,
  parameter int unsigned LW = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hpg_pkg::lvl_cmd_t cmd_i,
  input  logic [LW-1:0]     lvl_i,
  input  logic [LW-1:0]     n_i,
  output logic [AW-1:0]     cnt_o,
  output logic              wrap_o,
  output logic              last_o
);

  logic [AW-1:0] cnt_q [MAX_ELEMENTS+1];

  assign cnt_o  = cnt_q[lvl_i];
  // The level is done once its counter reaches one less than the level number
  assign wrap_o = (LW'(cnt_q[lvl_i]) + LW'(1)) >= lvl_i;

  // Last arrangement: every active level sits on its final pass
  always_comb begin
    last_o = 1'b1;
    for (int k = 2; k <= int'(MAX_ELEMENTS); k++) begin
      if (!((LW'(k) > n_i) || (cnt_q[k] == AW'(k - 1)))) begin
        last_o = 1'b0;
      end
    end
  end

  // Clear on restart, step the selected level while advancing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= int'(MAX_ELEMENTS); k++) begin
        cnt_q[k] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int k = 0; k <= int'(MAX_ELEMENTS); k++) begin
        cnt_q[k] <= '0;
      end
    end else if (cmd_i.step) begin
      if (wrap_o) begin
        cnt_q[lvl_i] <= '0;
      end else begin
        cnt_q[lvl_i] <= cnt_q[lvl_i] + AW'(1);
      end
    end
  end

endmodule
